// ===== hdl/fgm_pkg.sv =====
// Shared types and constants of the feature gallery matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package fgm_pkg;

   localparam int DIST_W = 40;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [4:0] LIMIT_RESET = 5'd16;

   // request types
   localparam logic [1:0] REQ_SEARCH = 2'd0;
   localparam logic [1:0] REQ_UPDATE = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MATCH   = 2'd0;
   localparam logic [1:0] CSR_NOVELTY = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   // result kinds
   localparam logic KIND_SEARCH = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic mac_issue;
      logic min_step;
      logic decide;
      logic copy_issue;
      logic commit;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic acc_elem;
      logic acc_mac;
      logic acc_last;
      logic cur_update;
      logic cur_last_cand;
      logic add_ok;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/fgm_ctrl.sv =====
// Controller state machine of the feature gallery matcher.
// Sequences accept, MAC pass, min pass, decision, copy and emit; uses fgm_pkg.
`default_nettype none
module fgm_ctrl #(
   parameter int GALLERY_DEPTH = 16,
   parameter int FEATURE_DIM   = 128,
   parameter int CW            = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire fgm_pkg::status_type  status,
   output fgm_pkg::cmd_type          cmd,
   output logic [CW-1:0]             cmd_index
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MAC    = 6'b000010,
      ST_MINS   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_COPY   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   localparam logic [CW-1:0] DEPTH_C    = CW'(GALLERY_DEPTH);
   localparam logic [CW-1:0] MAC_LAST   = CW'(GALLERY_DEPTH + 1);
   localparam logic [CW-1:0] MIN_LAST   = CW'(GALLERY_DEPTH - 1);
   localparam logic [CW-1:0] DIM_C      = CW'(FEATURE_DIM);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          last_ff, last_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign cmd_index = cnt_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in    = status.acc_last;
               if (status.acc_elem && status.acc_mac) begin
                  state_in = ST_MAC;
               end else if (status.acc_elem && status.acc_last) begin
                  state_in = ST_MINS;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = (cnt_ff < DEPTH_C);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MAC_LAST) begin
               cnt_in   = '0;
               state_in = last_ff ? ST_MINS : ST_IDLE;
            end
         end
         ST_MINS: begin
            cmd.min_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MIN_LAST) begin
               cnt_in   = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.cur_update) begin
               state_in = status.add_ok ? ST_COPY : ST_EMIT;
            end else begin
               state_in = status.cur_last_cand ? ST_EMIT : ST_IDLE;
            end
         end
         ST_COPY: begin
            cmd.copy_issue = (cnt_ff < DIM_C);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIM_C) begin
               cmd.commit = 1'b1;
               cnt_in     = '0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fgm_datapath.sv =====
// Datapath of the feature gallery matcher: gallery and update memories,
// shared multiply-accumulate, min pass, FIFO bookkeeping, output word; uses fgm_pkg.
`default_nettype none
module fgm_datapath #(
   parameter int GALLERY_DEPTH  = 16,
   parameter int FEATURE_DIM    = 128,
   parameter int MAX_CANDIDATES = 64,
   parameter int CW             = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [39:0]          csr_data,
   input  wire logic [1:0]           req_type,
   input  wire logic signed [15:0]   req_element_value,
   input  wire logic                 req_last_element,
   input  wire logic                 req_last_candidate,
   input  wire fgm_pkg::cmd_type     cmd,
   input  wire logic [CW-1:0]        cmd_index,
   output fgm_pkg::status_type       status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_result_kind,
   output logic                      rsp_match_found,
   output logic [5:0]                rsp_best_candidate,
   output logic [39:0]               rsp_least_distance,
   output logic                      rsp_entry_added,
   output logic [4:0]                rsp_gallery_count
);

   localparam int SW    = (GALLERY_DEPTH > 1) ? $clog2(GALLERY_DEPTH) : 1;
   localparam int CNTW  = $clog2(GALLERY_DEPTH + 1);
   localparam int PW    = $clog2(FEATURE_DIM);
   localparam int POSW  = $clog2(FEATURE_DIM + 2);
   localparam int CANDW = $clog2(MAX_CANDIDATES + 1);
   localparam int BPW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int LW    = (CNTW > 5) ? CNTW + 1 : 6;
   localparam int XW    = SW + CNTW + 1;
   localparam int AW    = SW + PW;
   localparam int DW    = fgm_pkg::DIST_W;

   localparam logic [POSW-1:0]  DIM_P    = POSW'(FEATURE_DIM);
   localparam logic [POSW-1:0]  DIM_SAT  = POSW'(FEATURE_DIM + 1);
   localparam logic [CNTW-1:0]  DEPTH_N  = CNTW'(GALLERY_DEPTH);
   localparam logic [SW-1:0]    SLOT_TOP = SW'(GALLERY_DEPTH - 1);
   localparam logic [XW-1:0]    DEPTH_X  = XW'(GALLERY_DEPTH);
   localparam logic [LW-1:0]    DEPTH_L  = LW'(GALLERY_DEPTH);
   localparam logic [CANDW-1:0] MAXC_C   = CANDW'(MAX_CANDIDATES);

   // configuration registers
   logic [DW-1:0] match_thr_ff, novelty_thr_ff;
   logic [4:0]    limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_thr_ff   <= '0;
         novelty_thr_ff <= '0;
         limit_ff       <= fgm_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == fgm_pkg::CSR_MATCH)   match_thr_ff   <= csr_data;
         if (csr_index == fgm_pkg::CSR_NOVELTY) novelty_thr_ff <= csr_data;
         if (csr_index == fgm_pkg::CSR_LIMIT)   limit_ff       <= csr_data[4:0];
      end
   end

   // effective gallery limit: zero acts as one, capped at the depth
   logic [LW-1:0] lim_raw, lim_eff;
   always_comb begin
      lim_raw = LW'(limit_ff);
      if (lim_raw == '0)          lim_eff = LW'(1);
      else if (lim_raw > DEPTH_L) lim_eff = DEPTH_L;
      else                        lim_eff = lim_raw;
   end

   // state
   logic [CNTW-1:0]  count_ff;
   logic [SW-1:0]    oldest_ff;
   logic [POSW-1:0]  pos_ff;
   logic             mode_ff;
   logic [CANDW-1:0] cand_ff;
   logic [DW-1:0]    best_ff;
   logic [BPW-1:0]   bpos_ff;
   logic [DW-1:0]    psum_ff [GALLERY_DEPTH];
   logic [DW-1:0]    min_ff;
   logic [PW-1:0]    mac_pos_ff;
   logic [15:0]      val_ff;
   logic             cur_update_ff, cur_lc_ff;
   logic             predrop_ff;
   logic [SW-1:0]    copy_slot_ff;

   // slot holds a complete entry
   function automatic logic slot_ok(input logic [SW-1:0] s, input logic [SW-1:0] o,
                                    input logic [CNTW-1:0] c);
      logic [XW-1:0] off;
      if (s >= o) off = XW'(s) - XW'(o);
      else        off = XW'(s) + DEPTH_X - XW'(o);
      return off < XW'(c);
   endfunction

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == SLOT_TOP) ? '0 : s + 1'b1;
   endfunction

   // accept-time decode on the live request word
   logic            is_elem, is_update;
   logic [POSW-1:0] pos_eff;
   assign is_elem   = (req_type == fgm_pkg::REQ_SEARCH) || (req_type == fgm_pkg::REQ_UPDATE);
   assign is_update = (req_type == fgm_pkg::REQ_UPDATE);
   always_comb begin
      pos_eff = pos_ff;
      if (is_elem && (mode_ff != is_update)) pos_eff = '0;
   end

   // gallery and update buffer memories
   logic [15:0] gal_mem [2**AW];
   logic [15:0] buf_mem [2**PW];
   logic [15:0] gal_rd_ff, buf_rd_ff;
   logic        copy_v_ff;
   logic [PW-1:0] copy_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.mac_issue) gal_rd_ff <= gal_mem[{cmd_index[SW-1:0], mac_pos_ff}];
      if (copy_v_ff)     gal_mem[{copy_slot_ff, copy_idx_ff}] <= buf_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && is_update && (pos_eff < DIM_P))
         buf_mem[pos_eff[PW-1:0]] <= req_element_value;
      if (cmd.copy_issue) buf_rd_ff <= buf_mem[cmd_index[PW-1:0]];
      copy_idx_ff <= cmd_index[PW-1:0];
   end

   // MAC pipeline: read, square, accumulate
   logic          v1_ff, v2_ff;
   logic [SW-1:0] s1_ff, s2_ff;
   logic [31:0]   prod_ff;
   logic signed [16:0] diff;
   logic [16:0]        absd;
   logic [DW:0]        acc_sum;

   assign diff = $signed({val_ff[15], val_ff}) - $signed({gal_rd_ff[15], gal_rd_ff});
   assign absd = diff[16] ? 17'(-diff) : 17'(diff);
   assign acc_sum = {1'b0, psum_ff[s2_ff]} + (DW+1)'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         copy_v_ff <= 1'b0;
      end else begin
         v1_ff     <= cmd.mac_issue && slot_ok(cmd_index[SW-1:0], oldest_ff, count_ff);
         v2_ff     <= v1_ff;
         copy_v_ff <= cmd.copy_issue;
      end
      s1_ff   <= cmd_index[SW-1:0];
      s2_ff   <= s1_ff;
      prod_ff <= absd[15:0] * absd[15:0];
   end

   // partial sums: cleared on a vector's first element, accumulated by the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GALLERY_DEPTH; i++) psum_ff[i] <= '0;
      end else if (cmd.accept && is_elem && (pos_eff == '0)) begin
         for (int i = 0; i < GALLERY_DEPTH; i++) psum_ff[i] <= '0;
      end else if (v2_ff) begin
         psum_ff[s2_ff] <= acc_sum[DW] ? fgm_pkg::DIST_MAX : acc_sum[DW-1:0];
      end
   end

   // decision values
   logic [DW-1:0]    vec_dist;
   logic             add_ok;
   logic             cand_open;
   logic [DW-1:0]    new_best;
   logic [BPW-1:0]   new_bpos;
   logic [LW-1:0]    count_l;
   assign vec_dist  = (pos_ff == DIM_P) ? min_ff : fgm_pkg::DIST_MAX;
   assign add_ok    = (pos_ff == DIM_P) && (vec_dist >= novelty_thr_ff);
   assign cand_open = (cand_ff < MAXC_C);
   assign count_l   = LW'(count_ff);
   always_comb begin
      new_best = best_ff;
      new_bpos = bpos_ff;
      if (cand_open && (vec_dist < best_ff)) begin
         new_best = vec_dist;
         new_bpos = cand_ff[BPW-1:0];
      end
   end

   // staged result word
   logic          st_kind_ff, st_match_ff, st_added_ff;
   logic [BPW-1:0] st_bpos_ff;
   logic [DW-1:0] st_dist_ff;

   // gallery bookkeeping and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         oldest_ff     <= '0;
         pos_ff        <= '0;
         mode_ff       <= 1'b0;
         cand_ff       <= '0;
         best_ff       <= fgm_pkg::DIST_MAX;
         bpos_ff       <= '0;
         min_ff        <= fgm_pkg::DIST_MAX;
         cur_update_ff <= 1'b0;
         cur_lc_ff     <= 1'b0;
         predrop_ff    <= 1'b0;
      end else begin
         if (cmd.accept) begin
            min_ff <= fgm_pkg::DIST_MAX;
            if (req_type == fgm_pkg::REQ_CLEAR) begin
               count_ff  <= '0;
               oldest_ff <= '0;
               pos_ff    <= '0;
               cand_ff   <= '0;
               best_ff   <= fgm_pkg::DIST_MAX;
               bpos_ff   <= '0;
            end else if (is_elem) begin
               mode_ff       <= is_update;
               cur_update_ff <= is_update;
               cur_lc_ff     <= req_last_candidate;
               mac_pos_ff    <= pos_eff[PW-1:0];
               val_ff        <= req_element_value;
               pos_ff        <= (pos_eff < DIM_SAT) ? pos_eff + 1'b1 : pos_eff;
               if (is_update && !mode_ff) begin
                  cand_ff <= '0;
                  best_ff <= fgm_pkg::DIST_MAX;
                  bpos_ff <= '0;
               end
            end
         end
         // running minimum over valid slots
         if (cmd.min_step && slot_ok(cmd_index[SW-1:0], oldest_ff, count_ff)
             && (psum_ff[cmd_index[SW-1:0]] < min_ff))
            min_ff <= psum_ff[cmd_index[SW-1:0]];
         if (cmd.decide) begin
            pos_ff <= '0;
            if (!cur_update_ff) begin
               st_kind_ff  <= fgm_pkg::KIND_SEARCH;
               st_match_ff <= (count_ff != '0) && (new_best < match_thr_ff);
               st_bpos_ff  <= new_bpos;
               st_dist_ff  <= new_best;
               st_added_ff <= 1'b0;
               if (cur_lc_ff) begin
                  cand_ff <= '0;
                  best_ff <= fgm_pkg::DIST_MAX;
                  bpos_ff <= '0;
               end else begin
                  best_ff <= new_best;
                  bpos_ff <= new_bpos;
                  if (cand_open) cand_ff <= cand_ff + 1'b1;
               end
            end else begin
               st_kind_ff  <= fgm_pkg::KIND_UPDATE;
               st_match_ff <= 1'b0;
               st_bpos_ff  <= '0;
               st_dist_ff  <= vec_dist;
               st_added_ff <= add_ok;
               predrop_ff  <= 1'b0;
               if (add_ok) begin
                  if (count_ff >= DEPTH_N) begin
                     // full: drop the oldest first and reuse its slot
                     oldest_ff    <= slot_inc(oldest_ff);
                     count_ff     <= count_ff - 1'b1;
                     predrop_ff   <= 1'b1;
                     copy_slot_ff <= oldest_ff;
                  end else if (XW'(oldest_ff) + XW'(count_ff) >= DEPTH_X) begin
                     copy_slot_ff <= SW'(XW'(oldest_ff) + XW'(count_ff) - DEPTH_X);
                  end else begin
                     copy_slot_ff <= SW'(XW'(oldest_ff) + XW'(count_ff));
                  end
               end else if (count_l > lim_eff) begin
                  oldest_ff <= slot_inc(oldest_ff);
                  count_ff  <= count_ff - 1'b1;
               end
            end
         end
         // new entry is in place
         if (cmd.commit) begin
            if (!predrop_ff && (count_l + 1'b1 > lim_eff)) begin
               oldest_ff <= slot_inc(oldest_ff);
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   // output word register
   logic           out_free;
   logic [BPW+5:0] bpos_x;
   logic [CNTW+4:0] count_x;
   assign out_free = !rsp_valid || !rsp_stall;
   assign bpos_x   = {6'b0, st_bpos_ff};
   assign count_x  = {5'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_result_kind    <= st_kind_ff;
         rsp_match_found    <= st_match_ff;
         rsp_best_candidate <= bpos_x[5:0];
         rsp_least_distance <= st_dist_ff;
         rsp_entry_added    <= st_added_ff;
         rsp_gallery_count  <= count_x[4:0];
      end
   end

   // status to the controller
   always_comb begin
      status               = '0;
      status.acc_elem      = is_elem;
      status.acc_mac       = (pos_eff < DIM_P);
      status.acc_last      = req_last_element;
      status.cur_update    = cur_update_ff;
      status.cur_last_cand = cur_lc_ff;
      status.add_ok        = add_ok;
      status.out_free      = out_free;
   end

endmodule
`default_nettype wire

// ===== hdl/feature_gallery_matcher.sv =====
// Top level of the feature gallery matcher: controller plus datapath.
// Depends on fgm_pkg, fgm_ctrl and fgm_datapath.
//
// Usage: words arrive on the req_ channel (valid/stall); results leave on the
// rsp_ channel from an output register. Each search or update word carries one
// vector element; a clear word empties the gallery and ends any open frame.
// Configuration (thresholds, gallery limit) is written through csr_ while idle.
// Each element word passes through the single shared multiply-accumulate,
// which visits each gallery slot once (read, square, add); elements past
// FEATURE_DIM skip it. A vector's last element adds a min pass over the
// gallery slots and a decision step; an appended update adds a copy from the
// update buffer into the gallery memory (one memory port each).
// A word that yields a result then passes through the emit state to load the
// output register. Clear and unused words are taken without leaving the idle
// state. A search frame returns one word after its last candidate; each update
// vector, complete or short, returns one word at its last element.
// Reset clears all control state; the gallery starts empty, no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// block keeps working on following words until it has a new result to place.
`default_nettype none
module feature_gallery_matcher #(
   parameter int GALLERY_DEPTH  = 16,
   parameter int FEATURE_DIM    = 128,
   parameter int MAX_CANDIDATES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [39:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [15:0] req_element_value,
   input  wire logic               req_last_element,
   input  wire logic               req_last_candidate,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_result_kind,
   output logic                    rsp_match_found,
   output logic [5:0]              rsp_best_candidate,
   output logic [39:0]             rsp_least_distance,
   output logic                    rsp_entry_added,
   output logic [4:0]              rsp_gallery_count
);

   localparam int CW = $clog2(FEATURE_DIM + GALLERY_DEPTH + 3);

   fgm_pkg::cmd_type    cmd;
   fgm_pkg::status_type status;
   logic [CW-1:0]       cmd_index;

   fgm_ctrl #(
      .GALLERY_DEPTH (GALLERY_DEPTH),
      .FEATURE_DIM   (FEATURE_DIM),
      .CW            (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .cmd_index (cmd_index)
   );

   fgm_datapath #(
      .GALLERY_DEPTH  (GALLERY_DEPTH),
      .FEATURE_DIM    (FEATURE_DIM),
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .CW             (CW)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_type           (req_type),
      .req_element_value  (req_element_value),
      .req_last_element   (req_last_element),
      .req_last_candidate (req_last_candidate),
      .cmd                (cmd),
      .cmd_index          (cmd_index),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_match_found    (rsp_match_found),
      .rsp_best_candidate (rsp_best_candidate),
      .rsp_least_distance (rsp_least_distance),
      .rsp_entry_added    (rsp_entry_added),
      .rsp_gallery_count  (rsp_gallery_count)
   );

endmodule
`default_nettype wire

// ===== hdl/fgm_checker.sv =====
// Port-level checker of the feature gallery matcher, bound to the top level.
// Depends on fgm_pkg and feature_gallery_matcher.
`default_nettype none
module fgm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_result_kind,
   input wire logic        rsp_match_found,
   input wire logic [39:0] rsp_least_distance,
   input wire logic        rsp_entry_added
);

   // a stalled word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a match implies a real distance, not the saturated value
   a_match_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_least_distance != fgm_pkg::DIST_MAX)
      else $error("match reported with saturated distance");

   // update results and appends never report a match
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_added || rsp_result_kind == fgm_pkg::KIND_UPDATE)
      |-> !rsp_match_found)
      else $error("result fields mix search and update");

   // an append is only ever flagged on an update result
   a_added_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_added |-> rsp_result_kind == fgm_pkg::KIND_UPDATE)
      else $error("append flagged on a search result");

endmodule

bind feature_gallery_matcher fgm_checker u_fgm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_match_found    (rsp_match_found),
   .rsp_least_distance (rsp_least_distance),
   .rsp_entry_added    (rsp_entry_added)
);
`default_nettype wire

// ===== bench/tb_feature_gallery_matcher.sv =====
// Testbench of the feature gallery matcher: directed and random words, with a
// built-in predictor of the gallery, searches and updates. Depends on fgm_pkg
// and feature_gallery_matcher.
`default_nettype none
module tb_feature_gallery_matcher;

   localparam int DEPTH = 16;
   localparam int DIM = 128;
   localparam int MAX_CAND = 64;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 300;
   localparam int RANDOM_WORDS = 400;

   typedef struct packed {
      logic        kind;
      logic        match;
      logic [5:0]  cand;
      logic [39:0] least;
      logic        added;
      logic [4:0]  count;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [39:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = fgm_pkg::REQ_SEARCH;
   logic signed [15:0] req_element_value = '0;
   logic req_last_element = 1'b0;
   logic req_last_candidate = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic rsp_match_found;
   logic [5:0] rsp_best_candidate;
   logic [39:0] rsp_least_distance;
   logic rsp_entry_added;
   logic [4:0] rsp_gallery_count;

   feature_gallery_matcher u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_element_value(req_element_value), .req_last_element(req_last_element),
      .req_last_candidate(req_last_candidate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_match_found(rsp_match_found),
      .rsp_best_candidate(rsp_best_candidate), .rsp_least_distance(rsp_least_distance),
      .rsp_entry_added(rsp_entry_added), .rsp_gallery_count(rsp_gallery_count)
   );

   always #10 clock = ~clock;

   // predictor state
   logic signed [15:0] gal [DEPTH][DIM];
   logic signed [15:0] upd_buf [DIM];
   logic [39:0] psum [DEPTH];
   int unsigned n_entries, oldest, elem_pos, cand_pos, best_pos;
   logic [39:0] best_dist;
   logic upd_mode;
   logic [39:0] match_thr, novelty_thr;
   logic [4:0] limit_reg;

   match_result_type expected_results [$];
   int errors = 0;
   int words_sent = 0;
   longint cycles = 0;
   bit quiet = 0;       // no idling on either side
   bit hold_request = 0;
   int hold_left = 0;
   logic signed [15:0] vec [0:131];

   // ---------------- predictor ----------------
   function automatic bit slot_live(int unsigned s);
      return ((s + DEPTH - oldest) % DEPTH) < n_entries;
   endfunction

   task automatic clear_frame();
      cand_pos = 0;
      best_dist = fgm_pkg::DIST_MAX;
      best_pos = 0;
   endtask

   task automatic add_element(logic signed [15:0] v);
      longint d, sum;
      if (elem_pos == 0)
         for (int s = 0; s < DEPTH; s++) psum[s] = '0;
      if (elem_pos < DIM) begin
         for (int s = 0; s < DEPTH; s++) begin
            if (slot_live(s)) begin
               d = longint'(v) - longint'(gal[s][elem_pos]);
               sum = longint'(psum[s]) + d * d;
               psum[s] = (sum > longint'(fgm_pkg::DIST_MAX)) ? fgm_pkg::DIST_MAX : sum[39:0];
            end
         end
      end
      if (elem_pos < DIM + 1) elem_pos++;
   endtask

   function automatic logic [39:0] least_distance();
      logic [39:0] m;
      m = fgm_pkg::DIST_MAX;
      if (elem_pos != DIM) return fgm_pkg::DIST_MAX;
      for (int s = 0; s < DEPTH; s++)
         if (slot_live(s) && psum[s] < m) m = psum[s];
      return m;
   endfunction

   task automatic drop_oldest();
      if (n_entries > 0) begin
         oldest = (oldest + 1) % DEPTH;
         n_entries--;
      end
   endtask

   task automatic predict_word(input logic [1:0] rt, input logic signed [15:0] v,
                               input logic le, input logic lc,
                               output bit got, output match_result_type r);
      logic [39:0] d;
      int unsigned lim, slot;
      bit ok, added, predropped;
      got = 0;
      r = '0;
      lim = (limit_reg == 0) ? 1 : limit_reg;
      if (lim > DEPTH) lim = DEPTH;
      if (rt == fgm_pkg::REQ_CLEAR) begin
         n_entries = 0;
         oldest = 0;
         elem_pos = 0;
         clear_frame();
      end else if (rt == fgm_pkg::REQ_SEARCH) begin
         if (upd_mode) elem_pos = 0;
         upd_mode = 0;
         add_element(v);
         if (le) begin
            d = least_distance();
            if (cand_pos < MAX_CAND) begin
               if (d < best_dist) begin
                  best_dist = d;
                  best_pos = cand_pos;
               end
               cand_pos++;
            end
            elem_pos = 0;
            if (lc) begin
               got = 1;
               r.kind = fgm_pkg::KIND_SEARCH;
               r.match = (n_entries > 0) && (best_dist < match_thr);
               r.cand = best_pos[5:0];
               r.least = best_dist;
               r.count = n_entries[4:0];
               clear_frame();
            end
         end
      end else if (rt == fgm_pkg::REQ_UPDATE) begin
         if (!upd_mode) begin
            elem_pos = 0;
            clear_frame();
         end
         upd_mode = 1;
         if (elem_pos < DIM) upd_buf[elem_pos] = v;
         add_element(v);
         if (le) begin
            ok = (elem_pos == DIM);
            d = least_distance();
            added = ok && (d >= novelty_thr);
            if (added) begin
               predropped = 0;
               if (n_entries >= DEPTH) begin
                  drop_oldest();
                  predropped = 1;
               end
               slot = (oldest + n_entries) % DEPTH;
               for (int e = 0; e < DIM; e++) gal[slot][e] = upd_buf[e];
               n_entries++;
               if (!predropped && n_entries > lim) drop_oldest();
            end else if (n_entries > lim) begin
               drop_oldest();
            end
            elem_pos = 0;
            got = 1;
            r.kind = fgm_pkg::KIND_UPDATE;
            r.least = d;
            r.added = added;
            r.count = n_entries[4:0];
         end
      end
   endtask

   // ---------------- driving ----------------
   task automatic send_word(input logic [1:0] rt, input logic signed [15:0] v,
                            input logic le, input logic lc);
      bit got;
      match_result_type r;
      if (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rt;
      req_element_value <= v;
      req_last_element <= le;
      req_last_candidate <= lc;
      do @(posedge clock); while (req_stall);
      predict_word(rt, v, le, lc, got, r);
      if (got) expected_results.insert(expected_results.size(), r);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [39:0] val);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         fgm_pkg::CSR_MATCH:   match_thr = val;
         fgm_pkg::CSR_NOVELTY: novelty_thr = val;
         fgm_pkg::CSR_LIMIT:   limit_reg = val[4:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] rand_elem();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // vec from random values, or close to a stored entry
   task automatic fill_vector(input bit near);
      int unsigned s;
      int t;
      s = (oldest + $urandom_range(n_entries > 0 ? n_entries - 1 : 0)) % DEPTH;
      for (int e = 0; e < DIM + 4; e++) begin
         if (near && n_entries > 0 && e < DIM) begin
            t = int'(gal[s][e]) + int'($urandom_range(0, 8)) - 4;
            vec[e] = (t > 32767) ? 16'sh7fff : (t < -32768) ? 16'sh8000 : t[15:0];
         end else begin
            vec[e] = rand_elem();
         end
      end
   endtask

   task automatic send_vector(input logic [1:0] rt, input int len, input logic lc);
      for (int e = 0; e < len; e++)
         send_word(rt, vec[e], e == len - 1, lc);
   endtask

   // ---------------- result check ----------------
   always @(posedge clock) begin
      match_result_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word kind %0d", rsp_result_kind);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_result_kind !== exp_r.kind) begin
                  $error("result_kind expected %0d got %0d", exp_r.kind, rsp_result_kind);
                  errors++;
               end
               if (rsp_match_found !== exp_r.match) begin
                  $error("match_found expected %0d got %0d", exp_r.match, rsp_match_found);
                  errors++;
               end
               if (rsp_best_candidate !== exp_r.cand) begin
                  $error("best_candidate expected %0d got %0d", exp_r.cand,
                         rsp_best_candidate);
                  errors++;
               end
               if (rsp_least_distance !== exp_r.least) begin
                  $error("least_distance expected %0d got %0d", exp_r.least,
                         rsp_least_distance);
                  errors++;
               end
               if (rsp_entry_added !== exp_r.added) begin
                  $error("entry_added expected %0d got %0d", exp_r.added, rsp_entry_added);
                  errors++;
               end
               if (rsp_gallery_count !== exp_r.count) begin
                  $error("gallery_count expected %0d got %0d", exp_r.count,
                         rsp_gallery_count);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall: long hold-off on request, else random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 18);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      // empty gallery search, extremes, ties across two short candidates
      send_word(fgm_pkg::REQ_SEARCH, 16'sh8000, 1'b0, 1'b0);
      send_word(fgm_pkg::REQ_SEARCH, 16'sh7fff, 1'b1, 1'b0);
      send_word(fgm_pkg::REQ_SEARCH, 16'sh0000, 1'b1, 1'b1);
      // short update: never appended
      send_word(fgm_pkg::REQ_UPDATE, 16'sh7fff, 1'b0, 1'b1);
      send_word(fgm_pkg::REQ_UPDATE, 16'sh8000, 1'b1, 1'b1);
      // unused request type and clear
      send_word(fgm_pkg::REQ_UNUSED, 16'sh1234, 1'b1, 1'b1);
      send_word(fgm_pkg::REQ_CLEAR, 16'sh0000, 1'b0, 1'b0);
      // mode change mid-vector both ways
      send_word(fgm_pkg::REQ_SEARCH, 16'sh0001, 1'b0, 1'b0);
      send_word(fgm_pkg::REQ_UPDATE, 16'shffff, 1'b0, 1'b0);
      send_word(fgm_pkg::REQ_SEARCH, 16'sh4000, 1'b1, 1'b1);
      send_word(fgm_pkg::REQ_SEARCH, 16'sh4000, 1'b1, 1'b0);
      send_word(fgm_pkg::REQ_UPDATE, 16'sh4000, 1'b1, 1'b0);
      send_word(fgm_pkg::REQ_SEARCH, 16'shc000, 1'b1, 1'b1);
      // frame aborted by clear
      send_word(fgm_pkg::REQ_SEARCH, 16'sh0000, 1'b1, 1'b0);
      send_word(fgm_pkg::REQ_CLEAR, 16'sh0000, 1'b1, 1'b1);
      send_word(fgm_pkg::REQ_SEARCH, 16'sh7fff, 1'b1, 1'b1);
   endtask

   // fill past the depth so the gallery wraps and drops its oldest entry
   task automatic test_fill();
      write_csr(fgm_pkg::CSR_NOVELTY, 40'd0);
      write_csr(fgm_pkg::CSR_LIMIT, 40'd16);
      quiet = 1;
      for (int i = 0; i < DEPTH + 1; i++) begin
         if (i == 0) for (int e = 0; e < DIM; e++) vec[e] = 16'sh7fff;
         else if (i == 1) for (int e = 0; e < DIM; e++) vec[e] = 16'sh8000;
         else fill_vector(0);
         send_vector(fgm_pkg::REQ_UPDATE, DIM, 1'b0);
      end
      quiet = 0;
      // exact copy of a stored entry: distance zero
      write_csr(fgm_pkg::CSR_MATCH, 40'd1);
      for (int e = 0; e < DIM; e++) vec[e] = gal[oldest][e];
      send_vector(fgm_pkg::REQ_SEARCH, DIM, 1'b1);
   endtask

   // receiver holds off while short updates pile up, then the results drain
   task automatic test_backpressure();
      hold_request = 1;
      for (int i = 0; i < 10; i++) begin
         vec[0] = rand_elem();
         send_vector(fgm_pkg::REQ_UPDATE, 1, 1'b0);
      end
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic change_config();
      case ($urandom_range(3))
         0: write_csr(fgm_pkg::CSR_MATCH, $urandom_range(1) ? fgm_pkg::DIST_MAX : 40'd0);
         1: write_csr(fgm_pkg::CSR_MATCH, 40'({$urandom_range(255), $urandom()}));
         2: write_csr(fgm_pkg::CSR_NOVELTY,
                      $urandom_range(1) ? 40'({$urandom_range(255), $urandom()})
                                        : 40'd2000);
         default: write_csr(fgm_pkg::CSR_LIMIT, 40'($urandom_range(31)));
      endcase
   endtask

   task automatic test_random();
      int start_words, ncand;
      start_words = words_sent;
      write_csr(fgm_pkg::CSR_NOVELTY, fgm_pkg::DIST_MAX);
      write_csr(fgm_pkg::CSR_LIMIT, 40'd0);
      write_csr(fgm_pkg::CSR_LIMIT, 40'd1);
      write_csr(fgm_pkg::CSR_NOVELTY, 40'd1000);
      write_csr(fgm_pkg::CSR_MATCH, 40'd500);
      while (words_sent - start_words < RANDOM_WORDS) begin
         if ($urandom_range(11) == 0) change_config();
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: begin
               fill_vector($urandom_range(2) == 0);
               send_vector(fgm_pkg::REQ_UPDATE, DIM, 1'b0);
            end
            6, 7, 8, 9, 10, 11: begin
               ncand = $urandom_range(1, 3);
               for (int c = 0; c < ncand; c++) begin
                  fill_vector(1'($urandom_range(1)));
                  send_vector(fgm_pkg::REQ_SEARCH, ($urandom_range(7) == 0) ? DIM + 1 : DIM,
                              c == ncand - 1);
               end
            end
            12, 13, 14: begin
               fill_vector(0);
               send_vector($urandom_range(1) ? fgm_pkg::REQ_UPDATE : fgm_pkg::REQ_SEARCH,
                           $urandom_range(1) ? $urandom_range(1, 5) : DIM + 2,
                           1'($urandom_range(1)));
            end
            15: send_word(fgm_pkg::REQ_CLEAR, rand_elem(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            16: send_word(fgm_pkg::REQ_UNUSED, rand_elem(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            17: begin
               // many short candidates: up to and past the candidate limit
               ncand = $urandom_range(60, 70);
               for (int c = 0; c < ncand; c++) begin
                  vec[0] = rand_elem();
                  send_vector(fgm_pkg::REQ_SEARCH, 1, c == ncand - 1);
               end
            end
            default: begin
               fill_vector(0);
               send_vector($urandom_range(1) ? fgm_pkg::REQ_UPDATE : fgm_pkg::REQ_SEARCH,
                           $urandom_range(1, 20), 1'b0);
            end
         endcase
      end
      write_csr(fgm_pkg::CSR_LIMIT, 40'd31);
      write_csr(fgm_pkg::CSR_MATCH, fgm_pkg::DIST_MAX);
      fill_vector(1);
      send_vector(fgm_pkg::REQ_SEARCH, DIM, 1'b1);
   endtask

   initial begin
      for (int s = 0; s < DEPTH; s++) psum[s] = '0;
      n_entries = 0;
      oldest = 0;
      elem_pos = 0;
      upd_mode = 0;
      clear_frame();
      match_thr = '0;
      novelty_thr = '0;
      limit_reg = fgm_pkg::LIMIT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
